[rtl/core/tlv_pkg.sv]
// Shared types, constants and helper functions of the tank liquid volume unit.
// Depends on nothing; the interfaces and the top level use it.
`default_nettype none

package tlv_pkg;

	// Default geometry of the length fields.
	localparam int FRAC_BITS_DEF = 8;
	localparam int DIM_BITS_DEF  = 16;

	// Volume result width and its saturation value.
	localparam int VOL_W = 34;
	localparam logic [VOL_W-1:0] VOL_MAX = '1;

	// Angle arithmetic: Q2.30 radians, carried in a 34-bit signed accumulator.
	localparam int ANG_W        = 30;
	localparam int ZW           = 34;
	localparam int CORDIC_STEPS = 30;
	localparam logic [31:0] PI_Q30      = 32'd3373259426;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

	// Width of the normalized vector before the rotation stages.
	localparam int NW = 41;

	// Configuration register map.
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS = 2'd0,
		REG_LENGTH = 2'd1,
		REG_ORIENT = 2'd2
	} cfg_reg_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ZERO  = 2'd1,
		ST_CLAMP = 2'd2
	} status_t;

	// Arctangent of 2^-i in Q2.30 radians.
	function automatic logic [31:0] atan_q30(input int unsigned i);
		logic [31:0] v;
		case (i)
			0:  v = 32'h3243F6A8;
			1:  v = 32'h1DAC6705;
			2:  v = 32'h0FADBAFC;
			3:  v = 32'h07F56EA6;
			4:  v = 32'h03FEAB76;
			5:  v = 32'h01FFD55B;
			6:  v = 32'h00FFFAAA;
			7:  v = 32'h007FFF55;
			8:  v = 32'h003FFFEA;
			9:  v = 32'h001FFFFD;
			10: v = 32'h000FFFFF;
			11: v = 32'h0007FFFF;
			12: v = 32'h0003FFFF;
			13: v = 32'h0001FFFF;
			14: v = 32'h0000FFFF;
			15: v = 32'h00007FFF;
			16: v = 32'h00003FFF;
			17: v = 32'h00001FFF;
			18: v = 32'h00000FFF;
			19: v = 32'h000007FF;
			20: v = 32'h000003FF;
			21: v = 32'h000001FF;
			22: v = 32'h000000FF;
			23: v = 32'h0000007F;
			24: v = 32'h0000003F;
			25: v = 32'h0000001F;
			26: v = 32'h0000000F;
			27: v = 32'h00000008;
			28: v = 32'h00000004;
			29: v = 32'h00000002;
			default: v = '0;
		endcase
		return v;
	endfunction

	// One radix-256 digit of a division by 100. The remainder in is below 100,
	// so the partial dividend stays below 25600 and a reciprocal multiply is exact.
	// Returns the quotient digit over the new remainder.
	function automatic logic [14:0] div100_step(input logic [6:0] rem, input logic [7:0] octet);
		logic [14:0] val;
		logic [29:0] prod;
		logic [7:0]  digit;
		logic [14:0] back;
		val   = {rem, octet};
		prod  = 30'(val) * 30'd20972;
		digit = prod[28:21];
		back  = 15'(digit) * 15'd100;
		return {digit, 7'(val - back)};
	endfunction

endpackage

`default_nettype wire

[rtl/core/tlv_if.sv]
// Valid/ready channel interfaces of the tank liquid volume unit.
// Depends on tlv_pkg for the default height width and the volume width.
`default_nettype none

interface tlv_in_if #(parameter int DIM_BITS = tlv_pkg::DIM_BITS_DEF);
	logic                valid;
	logic                ready;
	logic [DIM_BITS-1:0] liquid_height;

	modport source(output valid, output liquid_height, input ready);
	modport sink(input valid, input liquid_height, output ready);
endinterface

interface tlv_out_if;
	logic                       valid;
	logic                       ready;
	logic [tlv_pkg::VOL_W-1:0]  volume;
	logic [1:0]                 status;

	modport source(output valid, output volume, output status, input ready);
	modport sink(input valid, input volume, input status, output ready);
endinterface

`default_nettype wire

[rtl/core/tank_liquid_volume_unit.sv]
// Tank liquid volume unit: height sample in, liquid volume and status out.
// Depends on tlv_pkg and the channel interfaces in tlv_if.sv.
//
// Usage:
//   The sample channel carries one liquid height (unsigned, FRAC_BITS fraction
//   bits) per transfer. The result channel returns one volume (34 bits, FRAC_BITS
//   fraction bits, saturated) and a status code per sample, in order.
//   Radius, length and orientation are set on the write port (cfg_we, cfg_index,
//   cfg_wdata) while no sample is in flight.
//   One sample is taken every cycle while the result channel does not stall;
//   the depth is set by one square root stage per result bit and one CORDIC
//   stage per angle step.
//   At reset all stage valid bits clear, and the registers return to radius 1.0,
//   length 1.0 and vertical orientation.
//   When the receiver holds ready low with a result waiting, the whole pipeline
//   holds and sample ready drops in the same cycle; nothing is lost or repeated.
`default_nettype none

module tank_liquid_volume_unit #(
	parameter int FRAC_BITS = tlv_pkg::FRAC_BITS_DEF,
	parameter int DIM_BITS  = tlv_pkg::DIM_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [tlv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_BITS-1:0]           cfg_wdata,
	tlv_in_if.sink                             sample,
	tlv_out_if.source                          result
);
	import tlv_pkg::*;

	localparam int D = DIM_BITS;
	localparam int F = FRAC_BITS;

	// Stage map.
	localparam int SQ0  = 3;
	localparam int NRM0 = D + 3;
	localparam int NRM1 = D + 4;
	localparam int COR0 = D + 5;
	localparam int TH   = COR0 + CORDIC_STEPS;
	localparam int P1   = TH + 1;
	localparam int P2   = TH + 2;
	localparam int P3   = TH + 3;
	localparam int P4   = TH + 4;
	localparam int P5   = TH + 5;
	localparam int NS   = P5;

	// Internal widths.
	localparam int RW  = 2 * D + 1;
	localparam int XW  = 45;
	localparam int XAW = (3 * D + 10 > 42) ? 3 * D + 10 : 42;
	localparam int DVW = 41;
	localparam int AW  = 2 * D + 34;
	localparam int AR  = 2 * D + 4;
	localparam int LW  = (3 * D + 5 > 36) ? 3 * D + 5 : 36;

	typedef struct packed {
		logic [D-1:0]          h;
		logic [D-1:0]          hc;
		logic                  zero;
		logic                  clamp;
		logic signed [D:0]     d;
		logic [D-1:0]          ad;
		logic [2*D-1:0]        rr;
		logic [2*D-1:0]        v;
		logic [RW-1:0]         root;
		logic [2*D-1:0]        tlo;
		logic [2*D-1:0]        thi;
		logic [3*D-1:0]        t;
		logic                  satv;
		logic [DVW-1:0]        xd;
		logic [47:0]           qd;
		logic [6:0]            drem;
		logic [VOL_W-1:0]      vol_v;
		logic signed [XW-1:0]  x;
		logic signed [XW-1:0]  y;
		logic signed [ZW-1:0]  z;
		logic [31:0]           theta;
		logic [D+31:0]         sec_lo;
		logic [D+31:0]         sec_hi;
		logic [2*D-1:0]        triangle;
		logic [AW-1:0]         sector;
		logic [AR-1:0]         area_r;
		logic [2*D-1:0]        vl_lo;
		logic [2*D+3:0]        vl_hi;
		logic [VOL_W-1:0]      vol;
		status_t               status;
	} item_t;

	// Configuration registers.
	logic [D-1:0] radius_q;
	logic [D-1:0] length_q;
	logic         orient_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= D'(1) << F;
			length_q <= D'(1) << F;
			orient_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RADIUS: radius_q <= cfg_wdata;
				REG_LENGTH: length_q <= cfg_wdata;
				REG_ORIENT: orient_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Work done by stage k on the item coming from stage k-1.
	function automatic item_t stage_fn(input int unsigned k, input item_t a,
			input logic [D-1:0] r, input logic [D-1:0] l, input logic orient);
		item_t                o;
		logic [D:0]           two_r;
		logic [D:0]           rmh;
		logic [2*D:0]         vprod;
		logic [RW-1:0]        bitv;
		logic [RW-1:0]        sumv;
		int unsigned          i;
		int unsigned          b;
		int unsigned          idx;
		logic [XAW-1:0]       xprod;
		logic [XAW-1:0]       xsh;
		logic [47:0]          xd48;
		logic [6:0]           rem;
		logic [14:0]          dstep;
		logic [NW-1:0]        ux;
		logic [NW-1:0]        uy;
		logic [NW-1:0]        m;
		logic signed [XW-1:0] xs;
		logic signed [XW-1:0] ys;
		logic signed [XW-1:0] dx;
		logic signed [XW-1:0] dy;
		logic signed [ZW-1:0] zs;
		logic [31:0]          at;
		logic [AW-1:0]        tri_w;
		logic [AW-1:0]        area;
		logic [AW-1:0]        ar;
		logic [LW-1:0]        lsum;
		logic [LW-1:0]        lsh;
		logic [VOL_W-1:0]     vol_h;
		o = a;

		// Flags, clamped height, offset from the axis and r squared.
		if (k == 1) begin
			two_r   = {1'b0, r} << 1;
			o.zero  = (a.h == '0) || (r == '0);
			o.clamp = orient && ({1'b0, a.h} > two_r);
			o.hc    = o.clamp ? two_r[D-1:0] : a.h;
			o.d     = $signed({1'b0, r}) - $signed({1'b0, o.hc});
			o.ad    = o.d[D] ? D'(-o.d) : o.d[D-1:0];
			o.rr    = (2*D)'(r) * (2*D)'(r);
		end

		// Chord half-width squared and the vertical partial products.
		if (k == 2) begin
			rmh    = ({1'b0, r} << 1) - {1'b0, a.hc};
			vprod  = (2*D+1)'(a.hc) * (2*D+1)'(rmh);
			o.v    = vprod[2*D-1:0];
			o.root = '0;
			o.tlo  = (2*D)'(a.rr[D-1:0]) * (2*D)'(a.hc);
			o.thi  = (2*D)'(a.rr[2*D-1:D]) * (2*D)'(a.hc);
		end

		// Square root, one result bit per stage.
		if (k >= SQ0 && k < SQ0 + D) begin
			i    = k - SQ0;
			bitv = RW'(1) << (2 * D - 2 - 2 * i);
			sumv = a.root + bitv;
			if ({1'b0, a.v} >= sumv) begin
				o.v    = a.v - sumv[2*D-1:0];
				o.root = (a.root >> 1) + bitv;
			end else begin
				o.root = a.root >> 1;
			end
		end

		// Vertical volume: r*r*h, times 3.14, rounded, over four stages.
		if (k == 3) begin
			o.t = ((3*D)'(a.thi) << D) + (3*D)'(a.tlo);
		end
		if (k == 4) begin
			xprod  = XAW'(a.t) * XAW'(314) + (XAW'(50) << (2 * F));
			xsh    = xprod >> (2 * F);
			o.satv = xsh >= (XAW'(100) << VOL_W);
			o.xd   = xsh[DVW-1:0];
		end
		if (k == 5 || k == 6) begin
			xd48 = {{(48-DVW){1'b0}}, a.xd};
			rem  = (k == 5) ? 7'd0 : a.drem;
			for (int j = 0; j < 3; j++) begin
				idx   = (k == 5) ? 5 - j : 2 - j;
				dstep = div100_step(rem, xd48[8*idx +: 8]);
				o.qd[8*idx +: 8] = dstep[14:7];
				rem   = dstep[6:0];
			end
			o.drem = rem;
			if (k == 6) begin
				o.vol_v = a.satv ? VOL_MAX : o.qd[VOL_W-1:0];
			end
		end

		// Starting vector for the angle and the first half of the normalizing shift.
		if (k == NRM0) begin
			if (a.d[D]) begin
				ux  = NW'(a.root[D-1:0]);
				uy  = NW'(a.ad);
				o.z = $signed({2'b00, HALF_PI_Q30});
			end else begin
				ux  = NW'(a.ad);
				uy  = NW'(a.root[D-1:0]);
				o.z = '0;
			end
			for (int j = 0; j < 3; j++) begin
				b = 32 >> j;
				m = ux | uy;
				if ((m >> (NW - b)) == '0) begin
					ux = ux << b;
					uy = uy << b;
				end
			end
			o.x = {{(XW-NW){1'b0}}, ux};
			o.y = {{(XW-NW){1'b0}}, uy};
		end
		if (k == NRM1) begin
			ux = a.x[NW-1:0];
			uy = a.y[NW-1:0];
			for (int j = 0; j < 3; j++) begin
				b = 4 >> j;
				m = ux | uy;
				if ((m >> (NW - b)) == '0) begin
					ux = ux << b;
					uy = uy << b;
				end
			end
			o.x = {{(XW-NW){1'b0}}, ux};
			o.y = {{(XW-NW){1'b0}}, uy};
		end

		// CORDIC vectoring, one micro-rotation per stage.
		if (k >= COR0 && k < COR0 + CORDIC_STEPS) begin
			i  = k - COR0;
			xs = a.x;
			ys = a.y;
			zs = a.z;
			dx = ys >>> i;
			dy = xs >>> i;
			at = atan_q30(i);
			if (ys > 0) begin
				o.x = xs + dx;
				o.y = ys - dy;
				o.z = zs + $signed({2'b00, at});
			end else begin
				o.x = xs - dx;
				o.y = ys + dy;
				o.z = zs - $signed({2'b00, at});
			end
		end

		// Limit the angle to the range zero to pi.
		if (k == TH) begin
			zs = a.z;
			if (zs < 0) begin
				o.theta = '0;
			end else if (zs > $signed({2'b00, PI_Q30})) begin
				o.theta = PI_Q30;
			end else begin
				o.theta = zs[31:0];
			end
		end

		// Segment area: sector minus or plus the triangle, rounded.
		if (k == P1) begin
			o.sec_lo   = (D+32)'(a.rr[D-1:0]) * (D+32)'(a.theta);
			o.sec_hi   = (D+32)'(a.rr[2*D-1:D]) * (D+32)'(a.theta);
			o.triangle = (2*D)'(a.ad) * (2*D)'(a.root[D-1:0]);
		end
		if (k == P2) begin
			o.sector = (AW'(a.sec_hi) << D) + AW'(a.sec_lo);
		end
		if (k == P3) begin
			tri_w = AW'(a.triangle) << ANG_W;
			if (!a.d[D]) begin
				area = (a.sector < tri_w) ? '0 : a.sector - tri_w;
			end else begin
				area = a.sector + tri_w;
			end
			ar       = (area + (AW'(1) << (ANG_W - 1))) >> ANG_W;
			o.area_r = ar[AR-1:0];
		end

		// Times the length, rounded and saturated; final selection.
		if (k == P4) begin
			o.vl_lo = (2*D)'(l) * (2*D)'(a.area_r[D-1:0]);
			o.vl_hi = (2*D+4)'(l) * (2*D+4)'(a.area_r[AR-1:D]);
		end
		if (k == P5) begin
			lsum  = (LW'(a.vl_hi) << D) + LW'(a.vl_lo) + (LW'(1) << (2 * F - 1));
			lsh   = lsum >> (2 * F);
			vol_h = (lsh > LW'(VOL_MAX)) ? VOL_MAX : lsh[VOL_W-1:0];
			if (a.zero) begin
				o.vol    = '0;
				o.status = ST_ZERO;
			end else if (!orient) begin
				o.vol    = a.vol_v;
				o.status = ST_OK;
			end else begin
				o.vol    = vol_h;
				o.status = a.clamp ? ST_CLAMP : ST_OK;
			end
		end
		return o;
	endfunction

	// Pipeline registers; the whole pipeline moves when the last stage is free.
	item_t        pipe_s [1:NS];
	logic [NS:1]  vld_s;
	item_t        in_item;
	logic         adv;

	assign adv = !vld_s[NS] || result.ready;

	always_comb begin
		in_item   = '0;
		in_item.h = sample.liquid_height;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NS-1:1], sample.valid};
		end
	end

	for (genvar k = 1; k <= NS; k++) begin : g_stage
		item_t prev;
		if (k == 1) begin : g_first
			assign prev = in_item;
		end else begin : g_next
			assign prev = pipe_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				pipe_s[k] <= stage_fn(k, prev, radius_q, length_q, orient_q);
			end
		end
	end

	// Channel outputs.
	assign sample.ready  = adv;
	assign result.valid  = vld_s[NS];
	assign result.volume = pipe_s[NS].vol;
	assign result.status = pipe_s[NS].status;

`ifndef SYNTH
	// A waiting result that is not taken freezes the input side.
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !sample.ready)
		else $error("sample ready high while a result is stalled");

	// A zero height or radius always reports an empty tank.
	a_zero_volume: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status == ST_ZERO |-> result.volume == '0)
		else $error("zero status with nonzero volume");

	// A vertical tank never reports a clamped height.
	a_vert_noclamp: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !orient_q |-> result.status != ST_CLAMP)
		else $error("clamp status in vertical mode");
`endif

endmodule

`default_nettype wire
